// ===== rtl/core/mzs_pkg.sv =====
package mzs_pkg;

   // square sizes and the row width register are fixed at 11 bits
   localparam int SIZE_W = 11;
   localparam int ROW_WIDTH_W = 11;
   localparam int ROW_WIDTH_RESET = 1024;
   localparam logic [SIZE_W-1:0] SIZE_SAT = 11'd2047;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic blocked;     // cell is blocked
      logic frame_end;   // last cell of the matrix
      logic first_row;   // cell sits in the first row
      logic wrap_clear;  // row restarted early after a width change: drop neighbours
      logic row_end;     // last cell of its row
   } item_flags_type;

   typedef struct packed {
      logic stage_busy;   // back stage holds an item
      logic commit_last;  // back stage retires a frame_end item this cycle
   } back_status_type;

endpackage

// ===== rtl/core/max_zero_square_scan.sv =====
// Largest all-zero square in a binary matrix streamed in raster order.
// Request channel (req_valid/req_ready): one cell per request, req_cell_req
// is 1 for a blocked cell, req_frame_end marks the last cell of the matrix.
// Response channel (rsp_valid/rsp_ready): one response per matrix, carrying
// the side of the largest all-zero square, after the frame_end request.
// csr_wr_en/csr_wr_data write the row width; 0 acts as 1, values above
// MAX_COLS act as MAX_COLS. Write it only while no request is in flight.
// Throughput: one cell per cycle, sustained while no response stalls; the line
// buffer RAM gives one read and one write per cycle. A frame_end request
// passes through the queue, the RAM read and the scoring stage to its response.
// A stalled response holds in its output register; requests keep flowing
// until the next frame_end item waits in the scoring stage and the two-entry
// queue fills behind it; then req_ready drops. Reset clears the frame state
// and the queue and loads a row width of 1024 (clamped to MAX_COLS); the
// line buffer needs no clearing: the first row of each matrix never reads it.
module max_zero_square_scan #(
   parameter int MAX_COLS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_cell_req,
   input  logic                               req_frame_end,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mzs_pkg::SIZE_W-1:0]         rsp_max_square,
   input  logic                               csr_wr_en,
   input  logic [mzs_pkg::ROW_WIDTH_W-1:0]    csr_wr_data
);

   localparam int CW = $clog2(MAX_COLS);
   localparam int WW = CW + 1;
   localparam int FW = $bits(mzs_pkg::item_flags_type);
   localparam int QW = FW + CW;
   localparam int RESET_WIDTH =
      (mzs_pkg::ROW_WIDTH_RESET > MAX_COLS) ? MAX_COLS : mzs_pkg::ROW_WIDTH_RESET;

   logic [WW-1:0]            width_ff;
   logic [WW-1:0]            width_in;
   logic                     accept;
   logic                     q_full;
   logic                     q_not_empty;
   logic                     q_pop;
   logic [QW-1:0]            q_pop_data;
   mzs_pkg::item_flags_type  front_flags;
   logic [CW-1:0]            front_col;
   mzs_pkg::back_status_type back_status;

   always_comb begin
      width_in = width_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            width_in = WW'(1);
         end else if (int'(csr_wr_data) > MAX_COLS) begin
            width_in = WW'(MAX_COLS);
         end else begin
            width_in = WW'(csr_wr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WW'(RESET_WIDTH);
      end else begin
         width_ff <= width_in;
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   mzs_front #(
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .blocked   (req_cell_req),
      .frame_end (req_frame_end),
      .row_width (width_ff),
      .flags     (front_flags),
      .col       (front_col)
   );

   mzs_queue #(
      .WIDTH (QW),
      .DEPTH (mzs_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data ({front_flags, front_col}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_pop_data)
   );

   mzs_back #(
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_not_empty),
      .q_flags        (mzs_pkg::item_flags_type'(q_pop_data[QW-1:CW])),
      .q_col          (q_pop_data[CW-1:0]),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_max_square (rsp_max_square),
      .status         (back_status)
   );

   // width register always holds a usable row width
   a_width_range: assert property (@(posedge clock) disable iff (reset)
      width_ff != '0 && int'(width_ff) <= MAX_COLS)
      else $error("row width register out of range");

   // a square never exceeds MAX_COLS
   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_max_square) <= MAX_COLS)
      else $error("max_square larger than MAX_COLS");

   // retiring a frame_end item always raises the response
   a_last_to_rsp: assert property (@(posedge clock) disable iff (reset)
      back_status.commit_last |=> rsp_valid)
      else $error("frame_end retired without a response");

   // an idle block raises the response for a lone frame_end request
   a_idle_latency: assert property (@(posedge clock) disable iff (reset)
      accept && req_frame_end && !q_not_empty && !back_status.stage_busy
      && !rsp_valid |-> ##3 rsp_valid)
      else $error("response late for frame_end on idle block");

endmodule

// ===== rtl/core/mzs_ram.sv =====
module mzs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mzs_front.sv =====
module mzs_front #(
   parameter int MAX_COLS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         blocked,
   input  logic                         frame_end,
   input  logic [$clog2(MAX_COLS):0]    row_width,
   output mzs_pkg::item_flags_type      flags,
   output logic [$clog2(MAX_COLS)-1:0]  col
);

   localparam int CW = $clog2(MAX_COLS);
   localparam int WW = CW + 1;

   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic          first_row_ff;
   logic          first_row_in;
   logic          wrap;
   logic [CW-1:0] col_cur;
   logic [WW-1:0] col_next;
   logic          row_end;

   always_comb begin
      // a column at or past the width starts a new row
      wrap     = {1'b0, col_ff} >= row_width;
      col_cur  = wrap ? '0 : col_ff;
      col_next = {1'b0, col_cur} + WW'(1);
      row_end  = col_next >= row_width;

      flags.blocked    = blocked;
      flags.frame_end  = frame_end;
      flags.first_row  = first_row_ff;
      flags.wrap_clear = wrap && !first_row_ff;
      flags.row_end    = row_end;
      col              = col_cur;

      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (accept) begin
         if (frame_end) begin
            col_in       = '0;
            first_row_in = 1'b1;
         end else if (row_end) begin
            col_in       = '0;
            first_row_in = 1'b0;
         end else begin
            col_in       = col_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
      end else begin
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
      end
   end

endmodule

// ===== rtl/core/mzs_queue.sv =====
module mzs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff;
   logic [AW-1:0]    rd_ptr_in;
   logic [CNTW-1:0]  count_ff;
   logic [CNTW-1:0]  count_in;

   always_comb begin
      full      = count_ff == CNTW'(DEPTH);
      not_empty = count_ff != '0;
      pop_data  = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/mzs_back.sv =====
module mzs_back #(
   parameter int MAX_COLS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  mzs_pkg::item_flags_type             q_flags,
   input  logic [$clog2(MAX_COLS)-1:0]         q_col,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mzs_pkg::SIZE_W-1:0]          rsp_max_square,
   output mzs_pkg::back_status_type            status
);

   localparam int CW = $clog2(MAX_COLS);
   localparam int SW = mzs_pkg::SIZE_W;

   logic                    stage_valid_ff;
   logic                    stage_valid_in;
   mzs_pkg::item_flags_type stage_flags_ff;
   logic [CW-1:0]           stage_col_ff;
   logic                    fwd_hit_ff;
   logic [SW-1:0]           fwd_data_ff;
   logic [SW-1:0]           left_ff;
   logic [SW-1:0]           left_in;
   logic [SW-1:0]           diag_ff;
   logic [SW-1:0]           diag_in;
   logic [SW-1:0]           best_ff;
   logic [SW-1:0]           best_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [SW-1:0]           rsp_data_ff;
   logic [SW-1:0]           rsp_data_in;

   logic [SW-1:0] ram_rd_data;
   logic          commit;
   logic [SW-1:0] up;
   logic [SW-1:0] left_eff;
   logic [SW-1:0] diag_eff;
   logic [SW-1:0] min_ul;
   logic [SW-1:0] min3;
   logic [SW-1:0] score;
   logic [SW-1:0] best_new;

   mzs_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_COLS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (stage_col_ff),
      .wr_data (score),
      .rd_en   (q_pop),
      .rd_addr (q_col),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      // a frame_end item retires only when the result register can take it
      commit = stage_valid_ff
               && (!stage_flags_ff.frame_end || !rsp_valid_ff || rsp_ready);
      q_pop  = q_valid && (!stage_valid_ff || commit);

      // the line entry may have been written on the very edge it was read
      if (stage_flags_ff.first_row) begin
         up = '0;
      end else if (fwd_hit_ff) begin
         up = fwd_data_ff;
      end else begin
         up = ram_rd_data;
      end
      left_eff = stage_flags_ff.wrap_clear ? '0 : left_ff;
      diag_eff = stage_flags_ff.wrap_clear ? '0 : diag_ff;

      min_ul = (up < left_eff) ? up : left_eff;
      min3   = (min_ul < diag_eff) ? min_ul : diag_eff;

      if (stage_flags_ff.blocked) begin
         score = '0;
      end else if (stage_flags_ff.first_row || stage_col_ff == '0) begin
         score = SW'(1);
      end else if (min3 == mzs_pkg::SIZE_SAT) begin
         score = mzs_pkg::SIZE_SAT;
      end else begin
         score = min3 + SW'(1);
      end
      best_new = (score > best_ff) ? score : best_ff;

      stage_valid_in = stage_valid_ff;
      if (q_pop) begin
         stage_valid_in = 1'b1;
      end else if (commit) begin
         stage_valid_in = 1'b0;
      end

      left_in = left_ff;
      diag_in = diag_ff;
      best_in = best_ff;
      if (commit) begin
         best_in = best_new;
         if (stage_flags_ff.row_end) begin
            left_in = '0;
            diag_in = '0;
         end else begin
            left_in = score;
            diag_in = up;
         end
         if (stage_flags_ff.frame_end) begin
            left_in = '0;
            diag_in = '0;
            best_in = '0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (commit && stage_flags_ff.frame_end) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = best_new;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_valid      = rsp_valid_ff;
      rsp_max_square = rsp_data_ff;

      status.stage_busy  = stage_valid_ff;
      status.commit_last = commit && stage_flags_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         stage_flags_ff <= q_flags;
         stage_col_ff   <= q_col;
         fwd_hit_ff     <= commit && (stage_col_ff == q_col);
         fwd_data_ff    <= score;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         left_ff        <= '0;
         diag_ff        <= '0;
         best_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         left_ff        <= left_in;
         diag_ff        <= diag_in;
         best_ff        <= best_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

endmodule
